/* hdl/qte_pkg.sv */
// shared types, constants and the arctangent table for the quaternion to euler block
`default_nettype none
package qte_pkg;
	localparam int QFB     = 14;
	localparam int SH30    = 30 - 2 * QFB;
	localparam int ARG_W   = 36;
	localparam int ANG_W   = 34;
	localparam int CRD_W   = 33;
	localparam int SQ_W    = 62;
	localparam int SQ_CELLS = 31;
	localparam int TAB_LEN = 24;
	localparam int NORM_TOP = 29;

	localparam logic signed [ARG_W-1:0] ONE_A = ARG_W'(1) <<< (2 * QFB);
	localparam logic signed [ANG_W-1:0] ANG_PI = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;
	localparam logic signed [16:0] ROLL_LIM = 17'sd25736;
	localparam logic signed [16:0] PITCH_LIM = 17'sd12868;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [ANG_W-1:0] ang;
		logic                    skip;
	} crd_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] res;
	} sqr_t;

	typedef struct packed {
		logic signed [ARG_W-1:0] sinr;
		logic signed [ARG_W-1:0] cosr;
		logic signed [ARG_W-1:0] siny;
		logic signed [ARG_W-1:0] cosy;
		logic signed [31:0]      s30;
		logic                    clamped;
	} arg_t;

	function automatic logic signed [ANG_W-1:0] atan_tab(input int unsigned idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			0: v = 34'sh3243F6A8;
			1: v = 34'sh1DAC6705;
			2: v = 34'sh0FADBAFC;
			3: v = 34'sh07F56EA6;
			4: v = 34'sh03FEAB76;
			5: v = 34'sh01FFD55B;
			6: v = 34'sh00FFFAAA;
			7: v = 34'sh007FFF55;
			8: v = 34'sh003FFFEA;
			9: v = 34'sh001FFFFD;
			10: v = 34'sh000FFFFF;
			11: v = 34'sh0007FFFF;
			12: v = 34'sh0003FFFF;
			13: v = 34'sh0001FFFF;
			14: v = 34'sh0000FFFF;
			15: v = 34'sh00007FFF;
			16: v = 34'sh00003FFF;
			17: v = 34'sh00001FFF;
			18: v = 34'sh00000FFF;
			19: v = 34'sh000007FF;
			20: v = 34'sh000003FF;
			21: v = 34'sh000001FF;
			22: v = 34'sh000000FF;
			23: v = 34'sh0000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [16:0] to_q13(input logic signed [ANG_W-1:0] ang,
			input logic signed [16:0] lim);
		logic signed [ANG_W:0] t;
		logic signed [17:0] r;
		t = (ANG_W+1)'(ang) + (ANG_W+1)'(65536);
		r = 18'(t >>> 17);
		if (r > 18'(lim))
			r = 18'(lim);
		if (r < -18'(lim))
			r = -18'(lim);
		return 17'(r);
	endfunction
endpackage
`default_nettype wire

/* hdl/qte_sqrt_cell.sv */
// one digit step of the square root chain
`default_nettype none
module qte_sqrt_cell #(
	parameter int K = 30
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire qte_pkg::sqr_t d_in,
	output qte_pkg::sqr_t      d_out
);
	import qte_pkg::*;

	localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * K);

	logic [SQ_W-1:0] sum;
	sqr_t nxt;

	always_comb begin
		sum = d_in.res + BITV;
		if (d_in.rem >= sum) begin
			nxt.rem = d_in.rem - sum;
			nxt.res = (d_in.res >> 1) + BITV;
		end else begin
			nxt.rem = d_in.rem;
			nxt.res = d_in.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= nxt;
	end
endmodule
`default_nettype wire

/* hdl/qte_cordic_cell.sv */
// one vectoring rotation of the cordic chain
`default_nettype none
module qte_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire qte_pkg::crd_t d_in,
	output qte_pkg::crd_t      d_out
);
	import qte_pkg::*;

	localparam logic signed [ANG_W-1:0] TAB = atan_tab(IDX);

	logic signed [CRD_W-1:0] dx;
	logic signed [CRD_W-1:0] dy;
	crd_t nxt;

	always_comb begin
		dx  = d_in.y >>> IDX;
		dy  = d_in.x >>> IDX;
		nxt = d_in;
		if (!d_in.skip) begin
			if (d_in.y > 0) begin
				nxt.x   = d_in.x + dx;
				nxt.y   = d_in.y - dy;
				nxt.ang = d_in.ang + TAB;
			end else begin
				nxt.x   = d_in.x - dx;
				nxt.y   = d_in.y + dy;
				nxt.ang = d_in.ang - TAB;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= nxt;
	end
endmodule
`default_nettype wire

/* hdl/qte_atan2.sv */
// atan2 unit: quadrant fold, normalization and a chain of cordic cells
`default_nettype none
module qte_atan2 #(
	parameter int STEPS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic signed [qte_pkg::ARG_W-1:0] y_in,
	input  wire logic signed [qte_pkg::ARG_W-1:0] x_in,
	output logic signed [qte_pkg::ANG_W-1:0]      ang_out
);
	import qte_pkg::*;

	localparam int NCELL = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;

	logic signed [ARG_W-1:0] nx, ny;
	logic signed [ANG_W-1:0] a0;
	logic                    skp;

	logic signed [ARG_W-1:0] nx_s1, ny_s1, nx_s2, ny_s2;
	logic signed [ANG_W-1:0] a_s1, a_s2;
	logic                    skip_s1, skip_s2;
	logic [5:0]              len_s2;

	logic [ARG_W-1:0] ax, ay, mx;
	logic [5:0]       len;
	logic signed [ARG_W-1:0] xs, ys;
	crd_t             c0;
	crd_t             chain [0:NCELL];

	// special cases and quadrant fold
	always_comb begin
		nx  = x_in;
		ny  = y_in;
		a0  = '0;
		skp = 1'b0;
		if (y_in == '0) begin
			skp = 1'b1;
			a0  = (x_in < 0) ? ANG_PI : '0;
		end else if (x_in == '0) begin
			skp = 1'b1;
			a0  = (y_in > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
		end else if (x_in < 0) begin
			if (y_in >= 0) begin
				nx = y_in;
				ny = -x_in;
				a0 = ANG_HALF_PI;
			end else begin
				nx = -y_in;
				ny = x_in;
				a0 = -ANG_HALF_PI;
			end
		end
	end

	// leading one of the larger magnitude
	always_comb begin
		ax  = (nx_s1 < 0) ? ARG_W'(-nx_s1) : ARG_W'(nx_s1);
		ay  = (ny_s1 < 0) ? ARG_W'(-ny_s1) : ARG_W'(ny_s1);
		mx  = (ax > ay) ? ax : ay;
		len = '0;
		for (int i = 0; i < ARG_W; i++)
			if (mx[i])
				len = 6'(i + 1);
	end

	// common shift to put the top bit at position 28
	always_comb begin
		if (len_s2 > 6'(NORM_TOP)) begin
			xs = nx_s2 >>> (len_s2 - 6'(NORM_TOP));
			ys = ny_s2 >>> (len_s2 - 6'(NORM_TOP));
		end else begin
			xs = nx_s2 <<< (6'(NORM_TOP) - len_s2);
			ys = ny_s2 <<< (6'(NORM_TOP) - len_s2);
		end
		c0.x    = CRD_W'(xs);
		c0.y    = CRD_W'(ys);
		c0.ang  = a_s2;
		c0.skip = skip_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1    <= nx;
			ny_s1    <= ny;
			a_s1     <= a0;
			skip_s1  <= skp;
			nx_s2    <= nx_s1;
			ny_s2    <= ny_s1;
			a_s2     <= a_s1;
			skip_s2  <= skip_s1;
			len_s2   <= len;
			chain[0] <= c0;
		end
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		qte_cordic_cell #(
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.en    (en),
			.d_in  (chain[i]),
			.d_out (chain[i+1])
		);
	end

	assign ang_out = chain[NCELL].ang;
endmodule
`default_nettype wire

/* hdl/quaternion_to_euler_angles.sv */
// quaternion to zyx euler angles, top level
//
// s_tdata carries one quaternion word; m_tdata carries roll, pitch and yaw in
// radians as signed q3.13 (pitch as signed q2.13), and m_tuser flags a pitch
// argument that was clamped. a word is taken at every clock edge with tvalid
// and tready high. from acceptance to m_tvalid a word passes three product and
// argument stages, a 31-cell square root chain for the pitch cosine, three
// normalization stages, one cell per cordic step (at most 24) and the output
// register. roll and yaw ride a delay line beside the root chain.
// throughput is one word per cycle while s_tready is high; the three angles
// use parallel cordic chains. the whole pipeline advances together; when the
// receiver stalls the output register holds its word and one more lands in a
// skid register; s_tready drops only while that skid register is full.
// reset clears the valid bits of every stage and the output side; payload
// registers are not reset.
`default_nettype none
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // comp_w, comp_x, comp_y, comp_z
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // roll_angle, pitch_angle, yaw_angle, zero pad
	output logic [0:0]       m_tuser   // pitch_clamped
);
	import qte_pkg::*;

	localparam int NCELL    = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int ATAN_LAT = 3 + NCELL;
	localparam int DEPTH    = 3 + SQ_CELLS + ATAN_LAT;

	logic en;
	logic acc;
	logic [DEPTH-1:0] vld_q;

	logic signed [15:0] w, x, y, z;
	logic signed [31:0] wx_s1, yz_s1, wz_s1, xy_s1, wy_s1, zx_s1, xx_s1, yy_s1, zz_s1;

	logic signed [ARG_W-1:0] sinp;
	arg_t arg_c, arg_s2;
	logic [30:0] mg;
	logic [SQ_W-1:0] mgsq;
	sqr_t sqr_c;

	sqr_t sq [0:SQ_CELLS];
	arg_t dly_q [0:SQ_CELLS];
	logic [ATAN_LAT-1:0] clp_q;

	logic signed [ARG_W-1:0] py, px;
	logic signed [ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;
	logic signed [16:0] roll_r, pitch_r, yaw_r;
	logic [47:0] new_data;

	logic out_vld_q, skid_vld_q;
	logic [47:0] out_data_q, skid_data_q;
	logic out_user_q, skid_user_q;
	logic take, new_vld;

	assign en       = !skid_vld_q;
	assign s_tready = en;
	assign acc      = s_tvalid && s_tready;

	assign w = s_tdata[15:0];
	assign x = s_tdata[31:16];
	assign y = s_tdata[47:32];
	assign z = s_tdata[63:48];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[DEPTH-2:0], acc};
	end

	// full width products
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			wy_s1 <= w * y;
			zx_s1 <= z * x;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			zz_s1 <= z * z;
		end
	end

	// atan2 arguments and the clamped asin argument
	always_comb begin
		arg_c.sinr = (ARG_W'(wx_s1) + ARG_W'(yz_s1)) <<< 1;
		arg_c.cosr = ONE_A - ((ARG_W'(xx_s1) + ARG_W'(yy_s1)) <<< 1);
		arg_c.siny = (ARG_W'(wz_s1) + ARG_W'(xy_s1)) <<< 1;
		arg_c.cosy = ONE_A - ((ARG_W'(yy_s1) + ARG_W'(zz_s1)) <<< 1);
		sinp       = (ARG_W'(wy_s1) - ARG_W'(zx_s1)) <<< 1;
		arg_c.clamped = 1'b0;
		if (sinp > ONE_A) begin
			sinp = ONE_A;
			arg_c.clamped = 1'b1;
		end else if (sinp < -ONE_A) begin
			sinp = -ONE_A;
			arg_c.clamped = 1'b1;
		end
		arg_c.s30 = 32'(sinp <<< SH30);
	end

	// radicand of the pitch cosine
	always_comb begin
		mg        = (arg_s2.s30 < 0) ? 31'(-arg_s2.s30) : 31'(arg_s2.s30);
		mgsq      = mg * mg;
		sqr_c.rem = (SQ_W'(1) << 60) - mgsq;
		sqr_c.res = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s2   <= arg_c;
			sq[0]    <= sqr_c;
			dly_q[0] <= arg_s2;
			for (int i = 0; i < SQ_CELLS; i++)
				dly_q[i+1] <= dly_q[i];
			clp_q <= {clp_q[ATAN_LAT-2:0], dly_q[SQ_CELLS].clamped};
		end
	end

	for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sqrt
		qte_sqrt_cell #(
			.K (SQ_CELLS - 1 - j)
		) u_sqrt (
			.clk   (clk),
			.en    (en),
			.d_in  (sq[j]),
			.d_out (sq[j+1])
		);
	end

	assign py = ARG_W'(dly_q[SQ_CELLS].s30);
	assign px = ARG_W'($signed({1'b0, sq[SQ_CELLS].res[30:0]}));

	qte_atan2 #(
		.STEPS (CORDIC_STEPS)
	) u_roll (
		.clk     (clk),
		.en      (en),
		.y_in    (dly_q[SQ_CELLS].sinr),
		.x_in    (dly_q[SQ_CELLS].cosr),
		.ang_out (roll_ang)
	);

	qte_atan2 #(
		.STEPS (CORDIC_STEPS)
	) u_pitch (
		.clk     (clk),
		.en      (en),
		.y_in    (py),
		.x_in    (px),
		.ang_out (pitch_ang)
	);

	qte_atan2 #(
		.STEPS (CORDIC_STEPS)
	) u_yaw (
		.clk     (clk),
		.en      (en),
		.y_in    (dly_q[SQ_CELLS].siny),
		.x_in    (dly_q[SQ_CELLS].cosy),
		.ang_out (yaw_ang)
	);

	assign roll_r   = to_q13(roll_ang, ROLL_LIM);
	assign pitch_r  = to_q13(pitch_ang, PITCH_LIM);
	assign yaw_r    = to_q13(yaw_ang, ROLL_LIM);
	assign new_data = {1'b0, 16'(yaw_r), 15'(pitch_r), 16'(roll_r)};

	assign take    = out_vld_q && m_tready;
	assign new_vld = vld_q[DEPTH-1] && en;

	// output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take)
				skid_vld_q <= 1'b0;
		end else if (new_vld) begin
			if (out_vld_q && !take)
				skid_vld_q <= 1'b1;
			else
				out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (new_vld) begin
			if (out_vld_q && !take) begin
				skid_data_q <= new_data;
				skid_user_q <= clp_q[ATAN_LAT-1];
			end else begin
				out_data_q <= new_data;
				out_user_q <= clp_q[ATAN_LAT-1];
			end
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_user_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word without output word");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid filled without a stall");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868 &&
			$signed(m_tdata[30:16]) >= -15'sd12868))
		else $error("pitch out of range");
`endif
endmodule
`default_nettype wire
